// ===== rtl/core/b64d_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64d_pkg: shared types and constants of the strict base64 stream decoder
// Result records, the per-item push bundle and the base64 alphabet mapping.
// ----------------------------------------------------------------------------
package b64d_pkg;

    // Item codes
    localparam logic FUNC_CHAR   = 1'b0;
    localparam logic FUNC_END    = 1'b1;
    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    // Result lanes per item and default depth of the result queue
    localparam int B64D_LANES       = 3;
    localparam int B64D_QUEUE_DEPTH = 16;

    // Alphabet anchors
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
    localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
    localparam logic [7:0] CHAR_DIGIT_9 = 8'h39;
    localparam logic [7:0] CHAR_PLUS    = 8'h2B;
    localparam logic [7:0] CHAR_SLASH   = 8'h2F;
    localparam logic [7:0] CHAR_PAD     = 8'h3D;
    localparam logic [7:0] CHAR_SPACE   = 8'h20;
    localparam logic [7:0] CHAR_TAB     = 8'h09;
    localparam logic [7:0] CHAR_LF      = 8'h0A;
    localparam logic [7:0] CHAR_VT      = 8'h0B;
    localparam logic [7:0] CHAR_FF      = 8'h0C;
    localparam logic [7:0] CHAR_CR      = 8'h0D;

    localparam logic [5:0] SEXTET_LOWER_BASE = 6'd26;
    localparam logic [5:0] SEXTET_DIGIT_BASE = 6'd52;
    localparam logic [5:0] SEXTET_PLUS       = 6'd62;
    localparam logic [5:0] SEXTET_SLASH      = 6'd63;

    typedef struct packed {
        logic       bad;
        logic [5:0] value;
    } b64d_sextet_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
        logic       invalid;
        logic       last;
    } b64d_result_t;

    // Up to three results produced by one item, lane 0 first
    typedef struct packed {
        logic [1:0]                    num;
        b64d_result_t [B64D_LANES-1:0] res;
    } b64d_push_t;

    // Map one character to its sextet; value is zero for a bad character
    function automatic b64d_sextet_t b64d_map(input logic [7:0] c);
        b64d_sextet_t sx;
        sx.bad   = 1'b0;
        sx.value = 6'd0;
        if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
            sx.value = 6'(c - CHAR_UPPER_A);
        end
        else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
            sx.value = 6'(c - CHAR_LOWER_A) + SEXTET_LOWER_BASE;
        end
        else if (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9) begin
            sx.value = 6'(c - CHAR_DIGIT_0) + SEXTET_DIGIT_BASE;
        end
        else if (c == CHAR_PLUS) begin
            sx.value = SEXTET_PLUS;
        end
        else if (c == CHAR_SLASH) begin
            sx.value = SEXTET_SLASH;
        end
        else begin
            sx.bad = 1'b1;
        end
        return sx;
    endfunction

    function automatic logic b64d_is_space(input logic [7:0] c);
        return (c == CHAR_SPACE) || (c == CHAR_TAB) || (c == CHAR_CR) ||
               (c == CHAR_LF) || (c == CHAR_FF) || (c == CHAR_VT);
    endfunction

endpackage

// ===== rtl/core/b64d_decode.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64d_decode: input register and group decoder
// Registers each accepted request, then in one pass updates the group state
// and emits up to three results for the result queue.
// ----------------------------------------------------------------------------
module b64d_decode (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   take,
    input  logic                   func,
    input  logic [7:0]             character,
    output b64d_pkg::b64d_push_t   push
);
    import b64d_pkg::*;

    // Input register
    logic        stage_valid_reg;
    logic        stage_func_reg;
    logic [7:0]  stage_char_reg;

    // Group state
    logic [17:0] sextet_buf_reg,  sextet_buf_next;
    logic [1:0]  group_pos_reg,   group_pos_next;
    logic        third_pad_reg,   third_pad_next;
    logic        pad_closed_reg,  pad_closed_next;
    logic        fault_reg,       fault_next;
    logic        any_char_reg,    any_char_next;

    b64d_sextet_t sx;
    logic         is_pad;
    logic         is_space;
    logic [5:0]   first, second, third, fourth;
    logic         fault_v;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            stage_valid_reg <= 1'b0;
        end
        else begin
            stage_valid_reg <= take;
        end
    end

    always_ff @(posedge clk) begin
        if (take) begin
            stage_func_reg <= func;
            stage_char_reg <= character;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            sextet_buf_reg <= '0;
            group_pos_reg  <= '0;
            third_pad_reg  <= 1'b0;
            pad_closed_reg <= 1'b0;
            fault_reg      <= 1'b0;
            any_char_reg   <= 1'b0;
        end
        else begin
            sextet_buf_reg <= sextet_buf_next;
            group_pos_reg  <= group_pos_next;
            third_pad_reg  <= third_pad_next;
            pad_closed_reg <= pad_closed_next;
            fault_reg      <= fault_next;
            any_char_reg   <= any_char_next;
        end
    end

    always_comb begin
        sx       = b64d_map(stage_char_reg);
        is_pad   = (stage_char_reg == CHAR_PAD);
        is_space = b64d_is_space(stage_char_reg);
        first    = sextet_buf_reg[17:12];
        second   = sextet_buf_reg[11:6];
        third    = sextet_buf_reg[5:0];
        fourth   = is_pad ? 6'd0 : sx.value;
        fault_v  = fault_reg | pad_closed_reg;

        sextet_buf_next = sextet_buf_reg;
        group_pos_next  = group_pos_reg;
        third_pad_next  = third_pad_reg;
        pad_closed_next = pad_closed_reg;
        fault_next      = fault_reg;
        any_char_next   = any_char_reg;
        push            = '0;

        if (stage_valid_reg) begin
            if (stage_func_reg == FUNC_END) begin
                // Report status and clear everything for the next text
                push.num              = 2'd1;
                push.res[0].kind      = KIND_STATUS;
                push.res[0].invalid   = fault_reg | ~any_char_reg | (group_pos_reg != 2'd0);
                push.res[0].last      = 1'b1;
                sextet_buf_next = '0;
                group_pos_next  = '0;
                third_pad_next  = 1'b0;
                pad_closed_next = 1'b0;
                fault_next      = 1'b0;
                any_char_next   = 1'b0;
            end
            else if (!is_space) begin
                any_char_next = 1'b1;
                unique case (group_pos_reg)
                    2'd0: begin
                        fault_v         = fault_v | sx.bad;
                        sextet_buf_next = {sx.value, 12'd0};
                        third_pad_next  = 1'b0;
                        group_pos_next  = 2'd1;
                    end
                    2'd1: begin
                        fault_v               = fault_v | sx.bad;
                        sextet_buf_next[11:6] = sx.value;
                        group_pos_next        = 2'd2;
                    end
                    2'd2: begin
                        if (is_pad) begin
                            third_pad_next = 1'b1;
                        end
                        else begin
                            fault_v              = fault_v | sx.bad;
                            sextet_buf_next[5:0] = sx.value;
                        end
                        group_pos_next = 2'd3;
                    end
                    2'd3: begin
                        fault_v = fault_v | (~is_pad & sx.bad)
                                | (third_pad_reg & ~is_pad)
                                | (third_pad_reg & (second[3:0] != 4'd0))
                                | (is_pad & ~third_pad_reg & (third[1:0] != 2'd0));
                        if (!fault_v) begin
                            // A padded third forces a padded fourth, else fault above
                            push.num = third_pad_reg ? 2'd1 : (is_pad ? 2'd2 : 2'd3);
                            push.res[0].data_byte = {first, second[5:4]};
                            push.res[1].data_byte = {second[3:0], third[5:2]};
                            push.res[2].data_byte = {third[1:0], fourth};
                        end
                        pad_closed_next = pad_closed_reg | is_pad;
                        sextet_buf_next = '0;
                        third_pad_next  = 1'b0;
                        group_pos_next  = 2'd0;
                    end
                    default: begin
                        group_pos_next = 2'd0;
                    end
                endcase
                fault_next = fault_v;
            end
        end
    end

`ifndef SYNTH
    a_status_alone: assert property (@(posedge clk) disable iff (!rst_n)
        (stage_valid_reg && stage_func_reg == FUNC_END)
        |-> (push.num == 2'd1 && push.res[0].kind == KIND_STATUS))
        else $error("end request did not yield exactly one status");

    a_state_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (stage_valid_reg && stage_func_reg == FUNC_END)
        |=> (group_pos_reg == 2'd0 && !fault_reg && !any_char_reg && !pad_closed_reg))
        else $error("state not cleared after end of text");

    a_data_at_group_end: assert property (@(posedge clk) disable iff (!rst_n)
        (push.num != 2'd0 && push.res[0].kind == KIND_DATA)
        |-> (group_pos_reg == 2'd3 && !fault_reg && !pad_closed_reg))
        else $error("data bytes outside a clean group close");
`endif

endmodule

// ===== rtl/core/b64d_outq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64d_outq: result queue
// Takes up to three results per cycle, hands out one per cycle when popped.
// ----------------------------------------------------------------------------
module b64d_outq #(
    parameter int DEPTH = b64d_pkg::B64D_QUEUE_DEPTH
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  b64d_pkg::b64d_push_t   push,
    input  logic                   pop,
    output logic                   not_empty,
    output logic                   near_full,
    output b64d_pkg::b64d_result_t head
);
    import b64d_pkg::*;

    localparam int PTR_W       = $clog2(DEPTH);
    localparam int CNT_W       = $clog2(DEPTH + 1);
    // Room kept for the request in the input register plus one more request
    localparam int STALL_LEVEL = DEPTH - 2 * B64D_LANES;

    b64d_result_t mem [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg,  count_next;
    logic [PTR_W-1:0] lane_addr [B64D_LANES];

    always_comb begin
        for (int i = 0; i < B64D_LANES; i++) begin
            lane_addr[i] = wr_ptr_reg + PTR_W'(i);
        end
        wr_ptr_next = wr_ptr_reg + PTR_W'(push.num);
        rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
        count_next  = count_reg + CNT_W'(push.num) - CNT_W'(pop);
    end

    always_ff @(posedge clk) begin
        for (int i = 0; i < B64D_LANES; i++) begin
            if (2'(i) < push.num) begin
                mem[lane_addr[i]] <= push.res[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assign not_empty = (count_reg != '0);
    assign near_full = (count_reg > CNT_W'(STALL_LEVEL));
    assign head      = mem[rd_ptr_reg];

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (32'(count_reg) + 32'(push.num)) <= (DEPTH + 32'(pop)))
        else $error("result queue overflow");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) <= DEPTH)
        else $error("result queue count out of range");

    a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> (count_reg == $past(count_reg) + CNT_W'($past(push.num)) - 1'b1))
        else $error("result queue count lost a pop or push");
`endif

endmodule

// ===== rtl/core/strict_base64_stream_decoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// strict_base64_stream_decoder: base64 decoder, one char a cycle unless stalled
// Skips ASCII whitespace, decodes standard-alphabet groups of four into
// bytes with strict '=' padding, and closes each text with a status result.
// ----------------------------------------------------------------------------
//  channel | handshake           | payload
//  --------+---------------------+---------------------------------------
//  in      | in_valid / in_stall | func, character
//  out     | out_valid/out_stall | kind, data_byte, invalid, last
//
//  Throughput: one request per cycle while in_stall is low; results leave one
//  per cycle while out_stall is low. Each accepted request passes through the
//  decoder's input register, and its results are then written into the queue.
//  in_stall rises when the result queue holds more than QUEUE_DEPTH - 6
//  results, so a blocked output backs up into the input.
//  Reset (rst_n low, asynchronous) empties the queue and clears group state.
//  A stalled result stays at the head of the queue until it is taken.
// ----------------------------------------------------------------------------
module strict_base64_stream_decoder #(
    // Result queue depth: a power of two, at least 8
    parameter int QUEUE_DEPTH = b64d_pkg::B64D_QUEUE_DEPTH
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       func,
    input  logic [7:0] character,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       kind,
    output logic [7:0] data_byte,
    output logic       invalid,
    output logic       last
);
    import b64d_pkg::*;

    b64d_push_t   push;
    b64d_result_t head;
    logic         take;
    logic         pop;
    logic         q_not_empty;
    logic         q_near_full;

    // Accept a request whenever the queue has room for two requests' results
    assign in_stall = q_near_full;
    assign take     = in_valid & ~q_near_full;

    b64d_decode u_decode (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .func      (func),
        .character (character),
        .push      (push)
    );

    b64d_outq #(
        .DEPTH (QUEUE_DEPTH)
    ) u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .pop       (pop),
        .not_empty (q_not_empty),
        .near_full (q_near_full),
        .head      (head)
    );

    // Advance the queue head when the consumer takes a result
    assign out_valid = q_not_empty;
    assign pop       = q_not_empty & ~out_stall;
    assign kind      = head.kind;
    assign data_byte = head.data_byte;
    assign invalid   = head.invalid;
    assign last      = head.last;

endmodule

// ===== tb/tb_strict_base64_stream_decoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_strict_base64_stream_decoder: self-checking bench for the base64 decoder
// Streams directed and random texts through the decoder, predicts every data
// byte and status in a behavioral model, and checks each result in order.
// ----------------------------------------------------------------------------
module tb_strict_base64_stream_decoder;
    import b64d_pkg::*;

    localparam int HALF_PERIOD    = 5;
    localparam int RESET_CYCLES   = 8;
    localparam int MAX_REPORTS    = 10;
    localparam int SETTLE_CYCLES  = 16;
    localparam int RUN_LIMIT_NS   = 2_000_000;
    localparam int PHASE_REQUESTS = 105;

    // Bit 6 of a mapped sextet flags a character outside the alphabet
    localparam logic [6:0] SEXTET_BAD = 7'h40;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic       func;
    logic [7:0] character;
    logic       out_valid;
    logic       out_stall;
    logic       kind;
    logic [7:0] data_byte;
    logic       invalid;
    logic       last;

    // Behavioral copy of the decoder state
    logic [17:0] group_bits;
    logic [1:0]  group_count;
    logic        pad_in_third;
    logic        padded_done;
    logic        text_rejected;
    logic        text_started;

    // Results still owed by the decoder, oldest first
    b64d_result_t pending_results[$];

    int sender_idle_pct;
    int receiver_idle_pct;
    int mismatches;
    int results_checked;
    int counted_requests;
    int texts_closed;
    int texts_rejected;
    int bytes_decoded;

    strict_base64_stream_decoder dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .func      (func),
        .character (character),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .kind      (kind),
        .data_byte (data_byte),
        .invalid   (invalid),
        .last      (last)
    );

    always #HALF_PERIOD clk = ~clk;

    // ------------------------------------------------------------------
    // Character helpers
    // ------------------------------------------------------------------

    // Map a character to its sextet; flag anything outside the alphabet
    function automatic logic [6:0] sextet_of(input logic [7:0] c);
        if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z)
            return {1'b0, 6'(c - CHAR_UPPER_A)};
        if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z)
            return {1'b0, 6'(c - CHAR_LOWER_A) + SEXTET_LOWER_BASE};
        if (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9)
            return {1'b0, 6'(c - CHAR_DIGIT_0) + SEXTET_DIGIT_BASE};
        if (c == CHAR_PLUS)
            return {1'b0, SEXTET_PLUS};
        if (c == CHAR_SLASH)
            return {1'b0, SEXTET_SLASH};
        return SEXTET_BAD;
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        case (c)
            CHAR_SPACE, CHAR_TAB, CHAR_LF, CHAR_VT, CHAR_FF, CHAR_CR: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    // Alphabet character that encodes sextet s
    function automatic logic [7:0] alpha_char(input logic [5:0] s);
        if (s < SEXTET_LOWER_BASE)
            return CHAR_UPPER_A + 8'(s);
        if (s < SEXTET_DIGIT_BASE)
            return CHAR_LOWER_A + 8'(s - SEXTET_LOWER_BASE);
        if (s < SEXTET_PLUS)
            return CHAR_DIGIT_0 + 8'(s - SEXTET_DIGIT_BASE);
        if (s == SEXTET_PLUS)
            return CHAR_PLUS;
        return CHAR_SLASH;
    endfunction

    function automatic logic [7:0] blank_char(input int pick);
        case (pick)
            0:       return CHAR_SPACE;
            1:       return CHAR_TAB;
            2:       return CHAR_LF;
            3:       return CHAR_VT;
            4:       return CHAR_FF;
            default: return CHAR_CR;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Decoder prediction
    // ------------------------------------------------------------------

    task automatic clear_text();
        group_bits    = '0;
        group_count   = '0;
        pad_in_third  = 1'b0;
        padded_done   = 1'b0;
        text_rejected = 1'b0;
        text_started  = 1'b0;
    endtask

    task automatic owe_byte(input logic [7:0] b);
        b64d_result_t r;
        r.kind      = KIND_DATA;
        r.data_byte = b;
        r.invalid   = 1'b0;
        r.last      = 1'b0;
        pending_results.insert(pending_results.size(), r);
        bytes_decoded++;
    endtask

    // Advance the model by one accepted request and queue what it owes
    task automatic predict_request(input logic f, input logic [7:0] c);
        b64d_result_t r;
        logic [6:0]   sx;
        logic         pad;
        logic [5:0]   s1, s2, s3, s4;
        if (f == FUNC_END) begin
            r.kind      = KIND_STATUS;
            r.data_byte = '0;
            r.invalid   = text_rejected || !text_started || group_count != '0;
            r.last      = 1'b1;
            pending_results.insert(pending_results.size(), r);
            texts_closed++;
            if (r.invalid)
                texts_rejected++;
            clear_text();
            return;
        end
        if (is_blank(c))
            return;

        text_started = 1'b1;
        if (padded_done)
            text_rejected = 1'b1;
        pad = (c == CHAR_PAD);
        sx  = sextet_of(c);

        case (group_count)
            2'd0:
            begin
                if (sx[6])
                    text_rejected = 1'b1;
                group_bits   = {sx[5:0], 12'd0};
                pad_in_third = 1'b0;
                group_count  = 2'd1;
            end
            2'd1:
            begin
                if (sx[6])
                    text_rejected = 1'b1;
                group_bits[11:6] = sx[5:0];
                group_count      = 2'd2;
            end
            2'd2:
            begin
                // a pad here is legal only if the fourth character pads too
                if (pad)
                    pad_in_third = 1'b1;
                else
                begin
                    if (sx[6])
                        text_rejected = 1'b1;
                    group_bits[5:0] = sx[5:0];
                end
                group_count = 2'd3;
            end
            default:
            begin
                s1 = group_bits[17:12];
                s2 = group_bits[11:6];
                s3 = group_bits[5:0];
                s4 = pad ? 6'd0 : sx[5:0];
                if (!pad && sx[6])
                    text_rejected = 1'b1;
                if (pad_in_third && !pad)
                    text_rejected = 1'b1;
                // padded groups must leave their unused low bits at zero
                if (pad_in_third && s2[3:0] != '0)
                    text_rejected = 1'b1;
                if (pad && !pad_in_third && s3[1:0] != '0)
                    text_rejected = 1'b1;
                if (!text_rejected) begin
                    owe_byte({s1, s2[5:4]});
                    if (!pad_in_third)
                        owe_byte({s2[3:0], s3[5:2]});
                    if (!pad)
                        owe_byte({s3[1:0], s4});
                end
                if (pad)
                    padded_done = 1'b1;
                group_bits   = '0;
                pad_in_third = 1'b0;
                group_count  = 2'd0;
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------

    // Present one request, hold it through stalls, predict it on accept.
    // Valid stays high on return so back-to-back requests need no toggle.
    task automatic send_request(input logic f, input logic [7:0] c);
        if (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < sender_idle_pct);
        end
        in_valid  <= 1'b1;
        func      <= f;
        character <= c;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        counted_requests++;
        predict_request(f, c);
    endtask

    task automatic send_string(input string s);
        for (int i = 0; i < s.len(); i++)
            send_request(FUNC_CHAR, s[i]);
    endtask

    task automatic close_text();
        send_request(FUNC_END, 8'($urandom_range(255)));
    endtask

    // Drop valid and hold off until every owed result has been taken
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------

    always @(posedge clk) begin
        if (rst_n)
            out_stall <= ($urandom_range(99) < receiver_idle_pct);
    end

    task automatic flag_mismatch(input string what);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("MISMATCH at %0t ns: %s", $time, what);
    endtask

    always @(posedge clk) begin : check_result
        b64d_result_t want;
        if (rst_n && out_valid && !out_stall) begin
            if (pending_results.size() == 0)
                flag_mismatch($sformatf("unexpected result kind=%0d byte=%02h inv=%0d last=%0d",
                                        kind, data_byte, invalid, last));
            else
            begin
                want = pending_results.pop_front();
                results_checked++;
                if (kind !== want.kind || data_byte !== want.data_byte ||
                    invalid !== want.invalid || last !== want.last)
                    flag_mismatch($sformatf(
                        "expected kind=%0d byte=%02h inv=%0d last=%0d, got %0d %02h %0d %0d",
                        want.kind, want.data_byte, want.invalid, want.last,
                        kind, data_byte, invalid, last));
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Empty text and whitespace-only text both close as rejected
    task automatic test_empty_text();
        close_text();
        send_request(FUNC_CHAR, CHAR_VT);
        close_text();
    endtask

    // Alphabet extremes, blank inside the text, and a legal final '=='
    task automatic test_clean_groups();
        send_string("+/z9");
        send_request(FUNC_CHAR, CHAR_CR);
        send_string("AQ==");
        close_text();
    endtask

    // Pad in third place only, nonzero trailing bits, and data after padding
    task automatic test_padding_faults();
        send_string("AB=A");
        close_text();
        send_string("AB==QQ");
        close_text();
    endtask

    // '=' first, then byte extremes and a high-bit byte
    task automatic test_bad_characters();
        send_request(FUNC_CHAR, CHAR_PAD);
        send_request(FUNC_CHAR, 8'h00);
        send_request(FUNC_CHAR, 8'h80);
        send_request(FUNC_CHAR, 8'hFF);
        close_text();
    endtask

    // Mostly well-formed random texts; about one in five gets a random edit
    task automatic send_random_text();
        logic [7:0] text[$];
        int         groups;
        int         spot;
        logic       keep_clean;
        groups = $urandom_range(4);
        repeat (groups)
            repeat (4)
                text.insert(text.size(), alpha_char(6'($urandom_range(63))));

        keep_clean = ($urandom_range(3) != 0);
        case ($urandom_range(2))
            1:
            begin
                text.insert(text.size(), alpha_char(6'($urandom_range(63))));
                text.insert(text.size(), alpha_char(6'($urandom_range(63))));
                if (keep_clean)
                    text.insert(text.size(), alpha_char({4'($urandom_range(15)), 2'b00}));
                else
                    text.insert(text.size(), alpha_char(6'($urandom_range(63))));
                text.insert(text.size(), CHAR_PAD);
            end
            2:
            begin
                text.insert(text.size(), alpha_char(6'($urandom_range(63))));
                if (keep_clean)
                    text.insert(text.size(), alpha_char({2'($urandom_range(3)), 4'b0000}));
                else
                    text.insert(text.size(), alpha_char(6'($urandom_range(63))));
                text.insert(text.size(), CHAR_PAD);
                text.insert(text.size(), CHAR_PAD);
            end
            default: ;
        endcase

        if ($urandom_range(4) == 0) begin
            spot = (text.size() == 0) ? 0 : $urandom_range(text.size() - 1);
            case ($urandom_range(4))
                0:
                begin
                    if (text.size() != 0)
                        text[spot] = 8'($urandom_range(255));
                    else
                        text.insert(text.size(), 8'($urandom_range(255)));
                end
                1: text.insert(spot, 8'($urandom_range(255)));
                2:
                begin
                    if (text.size() != 0)
                        text.delete(spot);
                end
                3: text.insert(spot, CHAR_PAD);
                default:
                begin
                    // trail more characters behind a possibly padded group
                    repeat ($urandom_range(4, 1))
                        text.insert(text.size(), alpha_char(6'($urandom_range(63))));
                end
            endcase
        end

        foreach (text[i]) begin
            if ($urandom_range(9) == 0)
                send_request(FUNC_CHAR, blank_char($urandom_range(5)));
            send_request(FUNC_CHAR, text[i]);
        end
        close_text();
    endtask

    task automatic test_random_texts(input int tx_idle, input int rx_idle);
        int start;
        // let the pipe run dry before the stall mix changes
        drain_results();
        sender_idle_pct   = tx_idle;
        receiver_idle_pct = rx_idle;
        start = counted_requests;
        while (counted_requests - start < PHASE_REQUESTS)
            send_random_text();
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial begin
        clk               = 1'b0;
        rst_n             = 1'b0;
        in_valid          = 1'b0;
        func              = FUNC_CHAR;
        character         = '0;
        out_stall         = 1'b0;
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        mismatches        = 0;
        results_checked   = 0;
        counted_requests  = 0;
        texts_closed      = 0;
        texts_rejected    = 0;
        bytes_decoded     = 0;
        clear_text();

        repeat (RESET_CYCLES)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_text();
        test_clean_groups();
        test_padding_faults();
        test_bad_characters();
        test_random_texts(30, 88);
        test_random_texts(88, 30);
        test_random_texts(0, 0);

        // wait out anything still owed, then watch for strays
        drain_results();
        repeat (SETTLE_CYCLES)
            @(posedge clk);
        if (pending_results.size() != 0)
            flag_mismatch($sformatf("%0d results never arrived", pending_results.size()));

        $display("Covered %0d texts (%0d rejected) in %0d requests under three stall mixes",
                 texts_closed, texts_rejected, counted_requests);
        $display("Checked %0d results, %0d of them data bytes; %0d mismatches",
                 results_checked, bytes_decoded, mismatches);
        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Hard stop in case the decoder hangs
    initial begin
        #(RUN_LIMIT_NS);
        $display("Timeout with %0d results still owed", pending_results.size());
        $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/b64d_pkg.sv
rtl/core/b64d_decode.sv
rtl/core/b64d_outq.sv
rtl/core/strict_base64_stream_decoder.sv
tb/tb_strict_base64_stream_decoder.sv
